// File: rtl/ises_pkg.sv
// ----------------------------------------------------------------------------
// ises_pkg
// types, codes and sizes shared by the i2c event sequencer files
// ----------------------------------------------------------------------------
package ises_pkg;

    localparam int BUF_DEPTH = 32;
    localparam int IDX_W     = $clog2(BUF_DEPTH);
    localparam int CNT_W     = IDX_W + 1;
    localparam int BANK_W    = 2;
    localparam int RAM_DEPTH = 4 * BUF_DEPTH;

    typedef enum logic [2:0] {
        OP_STATUS  = 3'd0,
        OP_STAGE   = 3'd1,
        OP_START_W = 3'd2,
        OP_START_R = 3'd3,
        OP_POP     = 3'd4,
        OP_PRELOAD = 3'd5
    } opcode_t;

    typedef enum logic [2:0] {
        MODE_READY = 3'd0,
        MODE_MTX   = 3'd1,
        MODE_MRX   = 3'd2,
        MODE_STX   = 3'd3,
        MODE_SRX   = 3'd4
    } mode_t;

    localparam logic [2:0] ACT_NONE    = 3'd0;
    localparam logic [2:0] ACT_ACK     = 3'd1;
    localparam logic [2:0] ACT_NACK    = 3'd2;
    localparam logic [2:0] ACT_STOP    = 3'd3;
    localparam logic [2:0] ACT_RELEASE = 3'd4;
    localparam logic [2:0] ACT_HOLD    = 3'd5;
    localparam logic [2:0] ACT_START   = 3'd6;
    localparam logic [2:0] ACT_ADDR    = 3'd7;

    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_ADDR_NAK = 3'd1;
    localparam logic [2:0] ERR_DATA_NAK = 3'd2;
    localparam logic [2:0] ERR_ARB_LOST = 3'd3;
    localparam logic [2:0] ERR_BUS      = 3'd4;

    localparam logic [7:0] ST_BUS_ERR  = 8'h00;
    localparam logic [7:0] ST_START    = 8'h08;
    localparam logic [7:0] ST_RSTART   = 8'h10;
    localparam logic [7:0] ST_MT_SLA_A = 8'h18;
    localparam logic [7:0] ST_MT_SLA_N = 8'h20;
    localparam logic [7:0] ST_MT_DAT_A = 8'h28;
    localparam logic [7:0] ST_MT_DAT_N = 8'h30;
    localparam logic [7:0] ST_ARB_LOST = 8'h38;
    localparam logic [7:0] ST_MR_SLA_A = 8'h40;
    localparam logic [7:0] ST_MR_SLA_N = 8'h48;
    localparam logic [7:0] ST_MR_DAT_A = 8'h50;
    localparam logic [7:0] ST_MR_DAT_N = 8'h58;
    localparam logic [7:0] ST_SR_SLA   = 8'h60;
    localparam logic [7:0] ST_SR_ARB   = 8'h68;
    localparam logic [7:0] ST_SR_GEN   = 8'h70;
    localparam logic [7:0] ST_SR_GARB  = 8'h78;
    localparam logic [7:0] ST_SR_DAT_A = 8'h80;
    localparam logic [7:0] ST_SR_DAT_N = 8'h88;
    localparam logic [7:0] ST_SR_GDT_A = 8'h90;
    localparam logic [7:0] ST_SR_GDT_N = 8'h98;
    localparam logic [7:0] ST_SR_STOP  = 8'hA0;
    localparam logic [7:0] ST_ST_SLA   = 8'hA8;
    localparam logic [7:0] ST_ST_ARB   = 8'hB0;
    localparam logic [7:0] ST_ST_DAT_A = 8'hB8;
    localparam logic [7:0] ST_ST_DAT_N = 8'hC0;
    localparam logic [7:0] ST_ST_LAST  = 8'hC8;

    localparam logic [1:0] BANK_REPLY = 2'd3;

endpackage

// File: rtl/ises_req_if.sv
// ----------------------------------------------------------------------------
// ises_req_if
// input channel of the event sequencer: valid, ready and one item
// ----------------------------------------------------------------------------
interface ises_req_if;
    logic       valid;
    logic       ready;
    logic [2:0] opcode;
    logic [7:0] status_code;
    logic [7:0] bus_byte;
    logic [7:0] host_byte;
    logic [6:0] target_address;
    logic [5:0] read_count;
    logic       stop_after;

    modport source (output valid, opcode, status_code, bus_byte, host_byte,
                    target_address, read_count, stop_after, input ready);
    modport sink   (input valid, opcode, status_code, bus_byte, host_byte,
                    target_address, read_count, stop_after, output ready);
endinterface

// File: rtl/ises_rsp_if.sv
// ----------------------------------------------------------------------------
// ises_rsp_if
// result channel of the event sequencer: valid, ready and one result
// ----------------------------------------------------------------------------
interface ises_rsp_if;
    logic       valid;
    logic       ready;
    logic [2:0] bus_action;
    logic [7:0] data_out;
    logic       data_valid;
    logic [2:0] error_code;
    logic [2:0] mode_now;
    logic       accepted;
    logic       frame_done;
    logic [5:0] frame_length;

    modport source (output valid, bus_action, data_out, data_valid, error_code,
                    mode_now, accepted, frame_done, frame_length, input ready);
    modport sink   (input valid, bus_action, data_out, data_valid, error_code,
                    mode_now, accepted, frame_done, frame_length, output ready);
endinterface

// File: rtl/ises_ram.sv
// ----------------------------------------------------------------------------
// ises_ram
// generic single-port ram, registered read data held between reads
// ----------------------------------------------------------------------------
module ises_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/i2c_master_slave_event_sequencer_unit.sv
// ----------------------------------------------------------------------------
// i2c_master_slave_event_sequencer_unit
// event sequencer of an i2c controller, master and slave, buffers in one ram
// ----------------------------------------------------------------------------
// Takes one transaction per cycle and returns its result through the stage
// and output registers: the item is decided in the accept cycle while its
// single ram access (read or write) is issued, and the result then leaves
// through the output register, so sustained throughput is one item per cycle
// as long as results are taken. The staging, master and receive buffers are
// three banks of one 128x8 ram whose roles rotate, so starting a write or
// ending a master read swaps banks instead of copying; the slave reply
// buffer is the fourth bank. No clearing pass is needed after reset.
module i2c_master_slave_event_sequencer_unit (
    input  logic         clk,
    input  logic         rst_n,
    ises_req_if.sink     req,
    ises_rsp_if.source   rsp
);

    localparam int AW = ises_pkg::BANK_W + ises_pkg::IDX_W;
    localparam int CW = ises_pkg::CNT_W;
    localparam logic [CW-1:0] DEPTH_C = CW'(ises_pkg::BUF_DEPTH);

    ises_pkg::mode_t mode_reg, mode_next;
    logic          stop_flag_reg, stop_flag_next;
    logic          restart_reg, restart_next;
    logic [2:0]    err_reg, err_next;
    logic [7:0]    addr_byte_reg, addr_byte_next;
    logic [CW-1:0] mi_reg, mi_next, ml_reg, ml_next, sl_reg, sl_next;
    logic [CW-1:0] ri_reg, ri_next, rl_reg, rl_next;
    logic [CW-1:0] vi_reg, vi_next, vl_reg, vl_next;
    logic [ises_pkg::BANK_W-1:0] stg_reg, stg_next, mst_reg, mst_next;
    logic [ises_pkg::BANK_W-1:0] rcv_reg, rcv_next;

    logic          s1_v_reg, s1_move, acc;
    logic [2:0]    s1_act_reg, act;
    logic [7:0]    s1_dat_reg, dat;
    logic          s1_dv_reg, dv;
    logic          s1_ram_reg, use_ram;
    logic          s1_acc_reg, hacc;
    logic          s1_done_reg, done;
    logic [5:0]    s1_len_reg, len;
    logic [2:0]    s1_err_reg;
    logic [2:0]    s1_mode_reg;

    logic          o_v_reg;
    logic [2:0]    o_act_reg, o_err_reg, o_mode_reg;
    logic [7:0]    o_dat_reg;
    logic          o_dv_reg, o_acc_reg, o_done_reg;
    logic [5:0]    o_len_reg;

    logic          ram_we, ram_re;
    logic [AW-1:0] ram_addr;
    logic [7:0]    ram_wdata, ram_rdata;
    logic          end_ok, finish;
    logic [7:0]    st;
    logic [5:0]    cnt;

    assign s1_move   = s1_v_reg && (!o_v_reg || rsp.ready);
    assign req.ready = !s1_v_reg || s1_move;
    assign acc       = req.valid && req.ready;
    assign st        = req.status_code & 8'hF8;
    assign cnt       = req.read_count;

    always_comb
    begin
        mode_next      = mode_reg;
        stop_flag_next = stop_flag_reg;
        restart_next   = restart_reg;
        err_next       = err_reg;
        addr_byte_next = addr_byte_reg;
        mi_next = mi_reg; ml_next = ml_reg; sl_next = sl_reg;
        ri_next = ri_reg; rl_next = rl_reg;
        vi_next = vi_reg; vl_next = vl_reg;
        stg_next = stg_reg; mst_next = mst_reg; rcv_next = rcv_reg;
        ram_we = 1'b0; ram_re = 1'b0; ram_addr = '0; ram_wdata = 8'h00;
        act = ises_pkg::ACT_NONE; dat = 8'h00; dv = 1'b0; use_ram = 1'b0;
        hacc = 1'b0; done = 1'b0; len = 6'd0;
        end_ok = 1'b0; finish = 1'b0;
        if (acc)
        begin
            unique case (ises_pkg::opcode_t'(req.opcode))
                ises_pkg::OP_STATUS:
                begin
                    unique case (st)
                        ises_pkg::ST_START, ises_pkg::ST_RSTART:
                        begin
                            dat = addr_byte_reg; dv = 1'b1; act = ises_pkg::ACT_ACK;
                        end
                        ises_pkg::ST_MT_SLA_A, ises_pkg::ST_MT_DAT_A:
                        begin
                            if (mi_reg < ml_reg && mi_reg < DEPTH_C)
                            begin
                                ram_re = 1'b1; ram_addr = {mst_reg, mi_reg[ises_pkg::IDX_W-1:0]};
                                use_ram = 1'b1; dv = 1'b1;
                                mi_next = mi_reg + 1'b1; act = ises_pkg::ACT_ACK;
                            end
                            else
                            begin
                                end_ok = 1'b1;
                            end
                        end
                        ises_pkg::ST_MT_SLA_N, ises_pkg::ST_MR_SLA_N:
                        begin
                            err_next = ises_pkg::ERR_ADDR_NAK; act = ises_pkg::ACT_STOP;
                            finish = 1'b1;
                        end
                        ises_pkg::ST_MT_DAT_N:
                        begin
                            err_next = ises_pkg::ERR_DATA_NAK; act = ises_pkg::ACT_STOP;
                            finish = 1'b1;
                        end
                        ises_pkg::ST_ARB_LOST:
                        begin
                            err_next = ises_pkg::ERR_ARB_LOST; act = ises_pkg::ACT_RELEASE;
                            finish = 1'b1;
                        end
                        ises_pkg::ST_MR_DAT_A, ises_pkg::ST_MR_DAT_N:
                        begin
                            if (mi_reg < DEPTH_C)
                            begin
                                ram_we = 1'b1; ram_addr = {mst_reg, mi_reg[ises_pkg::IDX_W-1:0]};
                                ram_wdata = req.bus_byte; mi_next = mi_reg + 1'b1;
                            end
                            if (st == ises_pkg::ST_MR_DAT_N)
                            begin
                                end_ok = 1'b1;
                            end
                            else
                            begin
                                act = (mi_next < ml_reg) ? ises_pkg::ACT_ACK : ises_pkg::ACT_NACK;
                            end
                        end
                        ises_pkg::ST_MR_SLA_A:
                        begin
                            act = (mi_reg < ml_reg) ? ises_pkg::ACT_ACK : ises_pkg::ACT_NACK;
                        end
                        ises_pkg::ST_SR_SLA, ises_pkg::ST_SR_ARB,
                        ises_pkg::ST_SR_GEN, ises_pkg::ST_SR_GARB:
                        begin
                            mode_next = ises_pkg::MODE_SRX; rl_next = '0; ri_next = '0;
                            act = ises_pkg::ACT_ACK;
                        end
                        ises_pkg::ST_SR_DAT_A, ises_pkg::ST_SR_GDT_A:
                        begin
                            if (rl_reg < DEPTH_C)
                            begin
                                ram_we = 1'b1; ram_addr = {rcv_reg, rl_reg[ises_pkg::IDX_W-1:0]};
                                ram_wdata = req.bus_byte; rl_next = rl_reg + 1'b1;
                                act = ises_pkg::ACT_ACK;
                            end
                            else
                            begin
                                act = ises_pkg::ACT_NACK;
                            end
                        end
                        ises_pkg::ST_SR_DAT_N, ises_pkg::ST_SR_GDT_N:
                        begin
                            act = ises_pkg::ACT_NACK;
                        end
                        ises_pkg::ST_SR_STOP:
                        begin
                            act = ises_pkg::ACT_RELEASE; mode_next = ises_pkg::MODE_READY;
                            ri_next = '0; done = 1'b1; len = 6'(rl_reg);
                        end
                        ises_pkg::ST_ST_SLA, ises_pkg::ST_ST_ARB:
                        begin
                            mode_next = ises_pkg::MODE_STX;
                            ram_addr = {ises_pkg::BANK_REPLY, {ises_pkg::IDX_W{1'b0}}};
                            dv = 1'b1; vi_next = CW'(1);
                            if (vl_reg == '0)
                            begin
                                ram_we = 1'b1; ram_wdata = 8'h00; vl_next = CW'(1);
                            end
                            else
                            begin
                                ram_re = 1'b1; use_ram = 1'b1;
                            end
                            act = (vi_next < vl_next) ? ises_pkg::ACT_ACK : ises_pkg::ACT_NACK;
                        end
                        ises_pkg::ST_ST_DAT_A:
                        begin
                            dv = 1'b1;
                            if (vi_reg < vl_reg && vi_reg < DEPTH_C)
                            begin
                                ram_re = 1'b1; use_ram = 1'b1;
                                ram_addr = {ises_pkg::BANK_REPLY, vi_reg[ises_pkg::IDX_W-1:0]};
                                vi_next = vi_reg + 1'b1;
                            end
                            act = (vi_next < vl_reg) ? ises_pkg::ACT_ACK : ises_pkg::ACT_NACK;
                        end
                        ises_pkg::ST_ST_DAT_N, ises_pkg::ST_ST_LAST:
                        begin
                            act = ises_pkg::ACT_ACK; mode_next = ises_pkg::MODE_READY;
                            vl_next = '0; vi_next = '0;
                        end
                        ises_pkg::ST_BUS_ERR:
                        begin
                            err_next = ises_pkg::ERR_BUS; act = ises_pkg::ACT_STOP;
                            finish = 1'b1;
                        end
                        default:
                        begin
                        end
                    endcase
                end
                ises_pkg::OP_STAGE:
                begin
                    if (sl_reg < DEPTH_C)
                    begin
                        ram_we = 1'b1; ram_addr = {stg_reg, sl_reg[ises_pkg::IDX_W-1:0]};
                        ram_wdata = req.host_byte; sl_next = sl_reg + 1'b1; hacc = 1'b1;
                    end
                end
                ises_pkg::OP_START_W, ises_pkg::OP_START_R:
                begin
                    if (mode_reg == ises_pkg::MODE_READY &&
                        (req.opcode == ises_pkg::OP_START_W || cnt != 6'd0))
                    begin
                        if (req.opcode == ises_pkg::OP_START_W)
                        begin
                            stg_next = mst_reg; mst_next = stg_reg;
                            ml_next = sl_reg; sl_next = '0;
                            mode_next = ises_pkg::MODE_MTX;
                            addr_byte_next = {req.target_address, 1'b0};
                        end
                        else
                        begin
                            ml_next = (32'(cnt) > ises_pkg::BUF_DEPTH) ?
                                      CW'(ises_pkg::BUF_DEPTH - 1) : CW'(32'(cnt) - 1);
                            mode_next = ises_pkg::MODE_MRX;
                            addr_byte_next = {req.target_address, 1'b1};
                        end
                        stop_flag_next = req.stop_after;
                        err_next = ises_pkg::ERR_NONE;
                        mi_next = '0;
                        hacc = 1'b1;
                        if (restart_reg)
                        begin
                            restart_next = 1'b0; act = ises_pkg::ACT_ADDR;
                            dat = addr_byte_next; dv = 1'b1;
                        end
                        else
                        begin
                            act = ises_pkg::ACT_START;
                        end
                    end
                end
                ises_pkg::OP_POP:
                begin
                    if (ri_reg < rl_reg && ri_reg < DEPTH_C)
                    begin
                        ram_re = 1'b1; ram_addr = {rcv_reg, ri_reg[ises_pkg::IDX_W-1:0]};
                        use_ram = 1'b1; dv = 1'b1; ri_next = ri_reg + 1'b1; hacc = 1'b1;
                    end
                end
                ises_pkg::OP_PRELOAD:
                begin
                    if (vl_reg < DEPTH_C)
                    begin
                        ram_we = 1'b1;
                        ram_addr = {ises_pkg::BANK_REPLY, vl_reg[ises_pkg::IDX_W-1:0]};
                        ram_wdata = req.host_byte; vl_next = vl_reg + 1'b1; hacc = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
        if (end_ok)
        begin
            finish = 1'b1;
            if (stop_flag_reg)
            begin
                act = ises_pkg::ACT_STOP;
            end
            else
            begin
                restart_next = 1'b1; act = ises_pkg::ACT_HOLD;
            end
        end
        if (finish)
        begin
            if (mode_reg == ises_pkg::MODE_MRX)
            begin
                rcv_next = mst_reg; mst_next = rcv_reg;
                rl_next = mi_next; ri_next = '0;
                done = 1'b1; len = 6'(mi_next);
            end
            else if (mode_reg == ises_pkg::MODE_MTX)
            begin
                done = 1'b1;
            end
            mode_next = ises_pkg::MODE_READY;
        end
    end

    ises_ram #(.WIDTH(8), .DEPTH(ises_pkg::RAM_DEPTH)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .re    (ram_re),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= ises_pkg::MODE_READY;
            stop_flag_reg <= 1'b1; restart_reg <= 1'b0;
            err_reg <= ises_pkg::ERR_NONE; addr_byte_reg <= 8'h00;
            mi_reg <= '0; ml_reg <= '0; sl_reg <= '0;
            ri_reg <= '0; rl_reg <= '0; vi_reg <= '0; vl_reg <= '0;
            stg_reg <= 2'd0; mst_reg <= 2'd1; rcv_reg <= 2'd2;
            s1_v_reg <= 1'b0; o_v_reg <= 1'b0;
        end
        else
        begin
            mode_reg <= mode_next;
            stop_flag_reg <= stop_flag_next; restart_reg <= restart_next;
            err_reg <= err_next; addr_byte_reg <= addr_byte_next;
            mi_reg <= mi_next; ml_reg <= ml_next; sl_reg <= sl_next;
            ri_reg <= ri_next; rl_reg <= rl_next; vi_reg <= vi_next; vl_reg <= vl_next;
            stg_reg <= stg_next; mst_reg <= mst_next; rcv_reg <= rcv_next;
            if (req.ready)
            begin
                s1_v_reg <= acc;
            end
            if (s1_move)
            begin
                o_v_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                o_v_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            s1_act_reg <= act; s1_dat_reg <= dat; s1_dv_reg <= dv;
            s1_ram_reg <= use_ram; s1_acc_reg <= hacc; s1_done_reg <= done;
            s1_len_reg <= len; s1_err_reg <= err_next; s1_mode_reg <= mode_next;
        end
        if (s1_move)
        begin
            o_act_reg <= s1_act_reg;
            o_dat_reg <= s1_ram_reg ? ram_rdata : s1_dat_reg;
            o_dv_reg <= s1_dv_reg; o_acc_reg <= s1_acc_reg; o_done_reg <= s1_done_reg;
            o_len_reg <= s1_len_reg; o_err_reg <= s1_err_reg; o_mode_reg <= s1_mode_reg;
        end
    end

    assign rsp.valid        = o_v_reg;
    assign rsp.bus_action   = o_act_reg;
    assign rsp.data_out     = o_dat_reg;
    assign rsp.data_valid   = o_dv_reg;
    assign rsp.error_code   = o_err_reg;
    assign rsp.mode_now     = o_mode_reg;
    assign rsp.accepted     = o_acc_reg;
    assign rsp.frame_done   = o_done_reg;
    assign rsp.frame_length = o_len_reg;

    // buffer banks never alias
    assert property (@(posedge clk) disable iff (!rst_n)
        stg_reg != mst_reg && mst_reg != rcv_reg && stg_reg != rcv_reg &&
        stg_reg != ises_pkg::BANK_REPLY && mst_reg != ises_pkg::BANK_REPLY &&
        rcv_reg != ises_pkg::BANK_REPLY)
        else $error("buffer bank roles overlap");

    assert property (@(posedge clk) disable iff (!rst_n)
        ri_reg <= rl_reg && vi_reg <= vl_reg)
        else $error("read index beyond length");

    assert property (@(posedge clk) disable iff (!rst_n)
        mi_reg <= DEPTH_C && rl_reg <= DEPTH_C && sl_reg <= DEPTH_C && vl_reg <= DEPTH_C)
        else $error("buffer count beyond depth");

    // a stalled staged transaction keeps the ram read data untouched
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_v_reg && !s1_move |=> s1_v_reg && $stable(ram_rdata))
        else $error("staged read data lost while stalled");

endmodule

// File: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the i2c master/slave event sequencer: drives
// status events and host commands, predicts every result and compares
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;

    typedef struct packed {
        logic [2:0] op;
        logic [7:0] code;
        logic [7:0] bbyte;
        logic [7:0] hbyte;
        logic [6:0] addr;
        logic [5:0] cnt;
        logic       stop;
    } seq_item_t;

    typedef struct packed {
        logic [2:0] action;
        logic [7:0] data;
        logic       dvalid;
        logic [2:0] err;
        logic [2:0] mode;
        logic       acc;
        logic       done;
        logic [5:0] len;
    } seq_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    ises_req_if req();
    ises_rsp_if rsp();

    i2c_master_slave_event_sequencer_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    always #10 clk = ~clk;

    // sequencer state as seen by the bench
    logic [2:0] seq_mode = ises_pkg::MODE_READY;
    logic       stop_f = 1'b1;
    logic       restart_p = 1'b0;
    logic [2:0] last_err = ises_pkg::ERR_NONE;
    logic [7:0] addr_b = 8'h00;
    logic [7:0] mstore [ises_pkg::BUF_DEPTH];
    logic       mvalid [ises_pkg::BUF_DEPTH];
    logic [7:0] sstore [ises_pkg::BUF_DEPTH];
    logic [7:0] rstore [ises_pkg::BUF_DEPTH];
    logic [7:0] vstore [ises_pkg::BUF_DEPTH];
    logic       vvalid [ises_pkg::BUF_DEPTH];
    int midx = 0, mlen = 0, slen = 0, ridx = 0, rlen = 0, vidx = 0, vlen = 0;

    seq_result_t expected_results[$];
    int  errors = 0;
    int  sent = 0;
    bit  tx_idle_on = 1'b1;
    bit  rx_idle_on = 1'b1;
    int  hold_req = 0;
    int  hold_left = 0;
    int  stall = 0;

    task automatic emit(inout seq_result_t r, input logic [7:0] d);
        r.data = d;
        r.dvalid = 1'b1;
    endtask

    task automatic finish_master(inout seq_result_t r);
        int n;
        if (seq_mode == ises_pkg::MODE_MRX)
        begin
            n = (midx > ises_pkg::BUF_DEPTH) ? ises_pkg::BUF_DEPTH : midx;
            for (int i = 0; i < n; i++)
            begin
                vstore[i] = mstore[i];
                vvalid[i] = mvalid[i];
            end
            vlen = n;
            vidx = 0;
            r.done = 1'b1;
            r.len = 6'(n);
        end
        else if (seq_mode == ises_pkg::MODE_MTX)
        begin
            r.done = 1'b1;
            r.len = 6'd0;
        end
        seq_mode = ises_pkg::MODE_READY;
    endtask

    task automatic master_end_ok(inout seq_result_t r);
        if (stop_f)
            r.action = ises_pkg::ACT_STOP;
        else
        begin
            restart_p = 1'b1;
            r.action = ises_pkg::ACT_HOLD;
        end
        finish_master(r);
    endtask

    task automatic slave_send_next(inout seq_result_t r);
        if (ridx < rlen && ridx < ises_pkg::BUF_DEPTH)
        begin
            emit(r, rstore[ridx]);
            ridx++;
        end
        else
            emit(r, 8'h00);
        r.action = (ridx < rlen) ? ises_pkg::ACT_ACK : ises_pkg::ACT_NACK;
    endtask

    task automatic master_data_in(input logic [7:0] b);
        if (midx < ises_pkg::BUF_DEPTH)
        begin
            mstore[midx] = b;
            mvalid[midx] = 1'b1;
            midx++;
        end
    endtask

    task automatic bus_status(input seq_item_t it, inout seq_result_t r);
        case (it.code & 8'hF8)
            ises_pkg::ST_START, ises_pkg::ST_RSTART:
            begin
                emit(r, addr_b);
                r.action = ises_pkg::ACT_ACK;
            end
            ises_pkg::ST_MT_SLA_A, ises_pkg::ST_MT_DAT_A:
            begin
                if (midx < mlen && midx < ises_pkg::BUF_DEPTH)
                begin
                    emit(r, mstore[midx]);
                    midx++;
                    r.action = ises_pkg::ACT_ACK;
                end
                else
                    master_end_ok(r);
            end
            ises_pkg::ST_MT_SLA_N, ises_pkg::ST_MR_SLA_N:
            begin
                last_err = ises_pkg::ERR_ADDR_NAK;
                r.action = ises_pkg::ACT_STOP;
                finish_master(r);
            end
            ises_pkg::ST_MT_DAT_N:
            begin
                last_err = ises_pkg::ERR_DATA_NAK;
                r.action = ises_pkg::ACT_STOP;
                finish_master(r);
            end
            ises_pkg::ST_ARB_LOST:
            begin
                last_err = ises_pkg::ERR_ARB_LOST;
                r.action = ises_pkg::ACT_RELEASE;
                finish_master(r);
            end
            ises_pkg::ST_MR_DAT_A:
            begin
                master_data_in(it.bbyte);
                r.action = (midx < mlen) ? ises_pkg::ACT_ACK : ises_pkg::ACT_NACK;
            end
            ises_pkg::ST_MR_SLA_A:
                r.action = (midx < mlen) ? ises_pkg::ACT_ACK : ises_pkg::ACT_NACK;
            ises_pkg::ST_MR_DAT_N:
            begin
                master_data_in(it.bbyte);
                master_end_ok(r);
            end
            ises_pkg::ST_SR_SLA, ises_pkg::ST_SR_ARB, ises_pkg::ST_SR_GEN,
            ises_pkg::ST_SR_GARB:
            begin
                seq_mode = ises_pkg::MODE_SRX;
                vlen = 0;
                vidx = 0;
                r.action = ises_pkg::ACT_ACK;
            end
            ises_pkg::ST_SR_DAT_A, ises_pkg::ST_SR_GDT_A:
            begin
                if (vlen < ises_pkg::BUF_DEPTH)
                begin
                    vstore[vlen] = it.bbyte;
                    vvalid[vlen] = 1'b1;
                    vlen++;
                    r.action = ises_pkg::ACT_ACK;
                end
                else
                    r.action = ises_pkg::ACT_NACK;
            end
            ises_pkg::ST_SR_DAT_N, ises_pkg::ST_SR_GDT_N:
                r.action = ises_pkg::ACT_NACK;
            ises_pkg::ST_SR_STOP:
            begin
                r.action = ises_pkg::ACT_RELEASE;
                seq_mode = ises_pkg::MODE_READY;
                vidx = 0;
                r.done = 1'b1;
                r.len = 6'(vlen);
            end
            ises_pkg::ST_ST_SLA, ises_pkg::ST_ST_ARB:
            begin
                seq_mode = ises_pkg::MODE_STX;
                ridx = 0;
                if (rlen == 0)
                begin
                    rstore[0] = 8'h00;
                    rlen = 1;
                end
                slave_send_next(r);
            end
            ises_pkg::ST_ST_DAT_A:
                slave_send_next(r);
            ises_pkg::ST_ST_DAT_N, ises_pkg::ST_ST_LAST:
            begin
                r.action = ises_pkg::ACT_ACK;
                seq_mode = ises_pkg::MODE_READY;
                rlen = 0;
                ridx = 0;
            end
            ises_pkg::ST_BUS_ERR:
            begin
                last_err = ises_pkg::ERR_BUS;
                r.action = ises_pkg::ACT_STOP;
                if (seq_mode == ises_pkg::MODE_MTX || seq_mode == ises_pkg::MODE_MRX)
                    finish_master(r);
                else
                    seq_mode = ises_pkg::MODE_READY;
            end
            default: ;
        endcase
    endtask

    task automatic begin_master(input logic [2:0] m, input seq_item_t it, input logic rw,
                                inout seq_result_t r);
        seq_mode = m;
        stop_f = it.stop;
        last_err = ises_pkg::ERR_NONE;
        midx = 0;
        addr_b = {it.addr, rw};
        r.acc = 1'b1;
        if (restart_p)
        begin
            restart_p = 1'b0;
            r.action = ises_pkg::ACT_ADDR;
            emit(r, addr_b);
        end
        else
            r.action = ises_pkg::ACT_START;
    endtask

    task automatic predict_result(input seq_item_t it, output seq_result_t r);
        int c;
        r = '0;
        case (it.op)
            ises_pkg::OP_STATUS:
                bus_status(it, r);
            ises_pkg::OP_STAGE:
                if (slen < ises_pkg::BUF_DEPTH)
                begin
                    sstore[slen] = it.hbyte;
                    slen++;
                    r.acc = 1'b1;
                end
            ises_pkg::OP_START_W:
                if (seq_mode == ises_pkg::MODE_READY)
                begin
                    for (int i = 0; i < ises_pkg::BUF_DEPTH; i++)
                    begin
                        if (i < slen)
                            mstore[i] = sstore[i];
                        mvalid[i] = (i < slen);
                    end
                    mlen = slen;
                    slen = 0;
                    begin_master(ises_pkg::MODE_MTX, it, 1'b0, r);
                end
            ises_pkg::OP_START_R:
                if (seq_mode == ises_pkg::MODE_READY && it.cnt != 0)
                begin
                    c = (it.cnt > ises_pkg::BUF_DEPTH) ? ises_pkg::BUF_DEPTH : int'(it.cnt);
                    mlen = c - 1;
                    for (int i = 0; i < ises_pkg::BUF_DEPTH; i++)
                        mvalid[i] = 1'b0;
                    begin_master(ises_pkg::MODE_MRX, it, 1'b1, r);
                end
            ises_pkg::OP_POP:
                if (vidx < vlen && vidx < ises_pkg::BUF_DEPTH)
                begin
                    emit(r, vstore[vidx]);
                    vidx++;
                    r.acc = 1'b1;
                end
            ises_pkg::OP_PRELOAD:
                if (rlen < ises_pkg::BUF_DEPTH)
                begin
                    rstore[rlen] = it.hbyte;
                    rlen++;
                    r.acc = 1'b1;
                end
            default: ;
        endcase
        r.err = last_err;
        r.mode = seq_mode;
    endtask

    function automatic seq_item_t rnd_item();
        seq_item_t it;
        it.op    = 3'($urandom_range(7, 0));
        it.code  = 8'($urandom);
        it.bbyte = 8'($urandom);
        it.hbyte = 8'($urandom);
        it.addr  = 7'($urandom);
        it.cnt   = 6'($urandom);
        it.stop  = 1'($urandom);
        return it;
    endfunction

    task automatic send_item(input seq_item_t it);
        seq_item_t x;
        seq_result_t r;
        x = it;
        // never read a buffer entry that was not written
        if (x.op == ises_pkg::OP_STATUS && ((x.code & 8'hF8) == ises_pkg::ST_MT_SLA_A
            || (x.code & 8'hF8) == ises_pkg::ST_MT_DAT_A) && midx < mlen && !mvalid[midx])
            x.code = 8'hF8;
        if (x.op == ises_pkg::OP_POP && vidx < vlen && !vvalid[vidx])
            x.op = 3'd7;
        while (tx_idle_on && $urandom_range(99, 0) < 32)
        begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        req.valid          <= 1'b1;
        req.opcode         <= x.op;
        req.status_code    <= x.code;
        req.bus_byte       <= x.bbyte;
        req.host_byte      <= x.hbyte;
        req.target_address <= x.addr;
        req.read_count     <= x.cnt;
        req.stop_after     <= x.stop;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        predict_result(x, r);
        expected_results.push_back(r);
        sent++;
    endtask

    task automatic send_op(input logic [2:0] op);
        seq_item_t it;
        it = rnd_item();
        it.op = op;
        send_item(it);
    endtask

    task automatic send_status(input logic [7:0] code);
        seq_item_t it;
        it = rnd_item();
        it.op = ises_pkg::OP_STATUS;
        it.code = code | 8'($urandom_range(7, 0));
        send_item(it);
    endtask

    task automatic send_start(input logic [2:0] op, input int cnt, input logic stop);
        seq_item_t it;
        it = rnd_item();
        it.op = op;
        it.cnt = 6'(cnt);
        it.stop = stop;
        send_item(it);
    endtask

    task automatic master_write(input int n, input logic stop);
        for (int i = 0; i < n; i++)
            send_op(ises_pkg::OP_STAGE);
        send_start(ises_pkg::OP_START_W, $urandom_range(63, 0), stop);
        send_status($urandom_range(1, 0) ? ises_pkg::ST_START : ises_pkg::ST_RSTART);
        send_status(ises_pkg::ST_MT_SLA_A);
        for (int i = 0; i < n; i++)
            send_status(ises_pkg::ST_MT_DAT_A);
    endtask

    task automatic master_read(input int cnt, input logic stop);
        send_start(ises_pkg::OP_START_R, cnt, stop);
        send_status(ises_pkg::ST_START);
        send_status(ises_pkg::ST_MR_SLA_A);
        for (int i = 1; i < cnt; i++)
            send_status(ises_pkg::ST_MR_DAT_A);
        send_status(ises_pkg::ST_MR_DAT_N);
    endtask

    task automatic slave_receive(input int n);
        logic [7:0] codes [4] = '{ises_pkg::ST_SR_SLA, ises_pkg::ST_SR_ARB,
                                  ises_pkg::ST_SR_GEN, ises_pkg::ST_SR_GARB};
        send_status(codes[$urandom_range(3, 0)]);
        for (int i = 0; i < n; i++)
            send_status($urandom_range(1, 0) ? ises_pkg::ST_SR_DAT_A : ises_pkg::ST_SR_GDT_A);
        send_status($urandom_range(3, 0) == 0 ? ises_pkg::ST_SR_DAT_N : ises_pkg::ST_SR_STOP);
        send_status(ises_pkg::ST_SR_STOP);
    endtask

    task automatic slave_transmit(input int pre, input int reads);
        for (int i = 0; i < pre; i++)
            send_op(ises_pkg::OP_PRELOAD);
        send_status($urandom_range(1, 0) ? ises_pkg::ST_ST_SLA : ises_pkg::ST_ST_ARB);
        for (int i = 0; i < reads; i++)
            send_status(ises_pkg::ST_ST_DAT_A);
        send_status($urandom_range(1, 0) ? ises_pkg::ST_ST_DAT_N : ises_pkg::ST_ST_LAST);
    endtask

    task automatic pop_bytes(input int n);
        for (int i = 0; i < n; i++)
            send_op(ises_pkg::OP_POP);
    endtask

    task automatic test_master_paths();
        master_write(2, 1'b0);
        master_read(3, 1'b1);
        pop_bytes(4);
        send_start(ises_pkg::OP_START_R, 0, 1'b1);
        send_start(ises_pkg::OP_START_W, 1, 1'b1);
        send_start(ises_pkg::OP_START_R, 5, 1'b1);
        send_status(ises_pkg::ST_MT_SLA_N);
    endtask

    task automatic test_slave_paths();
        slave_receive(2);
        pop_bytes(3);
        slave_transmit(0, 1);
        slave_transmit(1, 2);
    endtask

    task automatic test_errors_and_noise();
        seq_item_t it;
        master_read(63, 1'b1);
        send_start(ises_pkg::OP_START_W, 0, 1'b1);
        send_status(ises_pkg::ST_MT_DAT_N);
        send_start(ises_pkg::OP_START_W, 0, 1'b1);
        send_status(ises_pkg::ST_ARB_LOST);
        send_status(ises_pkg::ST_BUS_ERR);
        send_status(8'hF8);
        it = rnd_item();
        it.op = 3'd6;
        send_item(it);
        it.op = 3'd7;
        send_item(it);
    endtask

    task automatic test_backpressure();
        hold_req = 300;
        for (int i = 0; i < 40; i++)
            send_op($urandom_range(1, 0) ? ises_pkg::OP_STAGE : ises_pkg::OP_PRELOAD);
        slave_transmit(0, 3);
    endtask

    task automatic test_random(input int total);
        int pick, n;
        while (sent < total)
        begin
            tx_idle_on = !(sent > 350 && sent < 550);
            rx_idle_on = tx_idle_on;
            pick = $urandom_range(99, 0);
            n = ($urandom_range(9, 0) == 0) ? $urandom_range(35, 28) : $urandom_range(5, 0);
            if (pick < 15)
                master_write(n, 1'($urandom_range(1, 0)));
            else if (pick < 30)
            begin
                master_read(($urandom_range(9, 0) == 0) ? $urandom_range(63, 0)
                            : $urandom_range(8, 1), 1'($urandom_range(1, 0)));
                pop_bytes($urandom_range(9, 0));
            end
            else if (pick < 45)
            begin
                slave_receive(n);
                pop_bytes(n + 1);
            end
            else if (pick < 60)
                slave_transmit(n, $urandom_range(n + 2, 0));
            else if (pick < 70)
            begin
                send_start($urandom_range(1, 0) ? ises_pkg::OP_START_W : ises_pkg::OP_START_R,
                           $urandom_range(63, 0), 1'($urandom_range(1, 0)));
                send_status(ises_pkg::ST_START);
                case ($urandom_range(4, 0))
                    0: send_status(ises_pkg::ST_MT_SLA_N);
                    1: send_status(ises_pkg::ST_MT_DAT_N);
                    2: send_status(ises_pkg::ST_ARB_LOST);
                    3: send_status(ises_pkg::ST_MR_SLA_N);
                    default: send_status(ises_pkg::ST_BUS_ERR);
                endcase
            end
            else if (pick < 80)
                send_op(3'($urandom_range(5, 1)));
            else
                send_item(rnd_item());
        end
    endtask

    // result side ready, with an optional long hold-off
    always @(posedge clk)
    begin
        if (hold_req > 0)
        begin
            hold_left = hold_req;
            hold_req = 0;
        end
        if (!rst_n)
            rsp.ready <= 1'b0;
        else if (hold_left > 0)
        begin
            hold_left--;
            rsp.ready <= 1'b0;
        end
        else
            rsp.ready <= !rx_idle_on || $urandom_range(99, 0) >= 32;
    end

    task automatic check_field(input string name, input int exp, input int act);
        if (exp != act)
        begin
            $error("%s mismatch: expected %0d actual %0d", name, exp, act);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        seq_result_t e;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result transaction with no expectation pending");
                errors++;
            end
            else
            begin
                e = expected_results.pop_front();
                check_field("bus_action", int'(e.action), int'(rsp.bus_action));
                check_field("data_out", int'(e.data), int'(rsp.data_out));
                check_field("data_valid", int'(e.dvalid), int'(rsp.data_valid));
                check_field("error_code", int'(e.err), int'(rsp.error_code));
                check_field("mode_now", int'(e.mode), int'(rsp.mode_now));
                check_field("accepted", int'(e.acc), int'(rsp.accepted));
                check_field("frame_done", int'(e.done), int'(rsp.frame_done));
                check_field("frame_length", int'(e.len), int'(rsp.frame_length));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((req.valid && req.ready) || (rsp.valid && rsp.ready)
            || (!req.valid && expected_results.size() == 0))
            stall = 0;
        else
            stall++;
        if (stall >= 3000)
        begin
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        req.valid = 1'b0;
        req.opcode = ises_pkg::OP_STATUS;
        req.status_code = 8'h00;
        req.bus_byte = 8'h00;
        req.host_byte = 8'h00;
        req.target_address = 7'h00;
        req.read_count = 6'd0;
        req.stop_after = 1'b0;
        for (int i = 0; i < ises_pkg::BUF_DEPTH; i++)
        begin
            mvalid[i] = 1'b0;
            vvalid[i] = 1'b0;
        end
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_master_paths();
        test_slave_paths();
        test_errors_and_noise();
        test_backpressure();
        test_random(950);
        req.valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (errors == 0 && expected_results.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// File: i2c_master_slave_event_sequencer_unit.f
rtl/ises_pkg.sv
rtl/ises_req_if.sv
rtl/ises_rsp_if.sv
rtl/ises_ram.sv
rtl/i2c_master_slave_event_sequencer_unit.sv
verif/tb_top.sv
